// ===== rtl/bdvf_pkg.sv =====
// shared constants, types and helper functions of the box downscaler
package bdvf_pkg;

    localparam int MAX_OUT_WIDTH = 2048;
    localparam int MAX_FACTOR    = 8;
    localparam int ROW_LIMIT     = 2048;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 20;
    localparam int CFG_W   = 12;
    localparam int FAC_W   = 4;
    localparam int ROW_W   = 11;
    localparam int COL_W   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int SUB_W   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int RAM_W   = 3 * SUM_W;

    // reciprocal multiply: q = (s * M) >> RECIP_SHIFT, exact for SUM_W-bit s
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // configuration port
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;
    localparam int IDX_W   = 2;
    localparam logic [IDX_W-1:0] REG_OUT_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_OUT_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FACTOR     = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } sum_t;

    // per-item control that travels along with the pixel
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             emit;
        logic             load;
    } item_ctl_t;

    function automatic logic [FAC_W-1:0] eff_factor(input logic [FAC_W-1:0] v);
        logic [FAC_W-1:0] res;
        if (v == '0) begin
            res = FAC_W'(1);
        end else if (int'(v) > MAX_FACTOR) begin
            res = FAC_W'(MAX_FACTOR);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (int'(v) > MAX_OUT_WIDTH) begin
            res = CFG_W'(MAX_OUT_WIDTH);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] eff_height(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (int'(v) > ROW_LIMIT) begin
            res = CFG_W'(ROW_LIMIT);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // ceil(2^RECIP_SHIFT / (f*f)) for each factor
    function automatic logic [RECIP_W-1:0] recip(input logic [FAC_W-1:0] f);
        logic [RECIP_W-1:0] m;
        case (f)
            4'd1:    m = RECIP_W'(134217728);
            4'd2:    m = RECIP_W'(33554432);
            4'd3:    m = RECIP_W'(14913081);
            4'd4:    m = RECIP_W'(8388608);
            4'd5:    m = RECIP_W'(5368710);
            4'd6:    m = RECIP_W'(3728271);
            4'd7:    m = RECIP_W'(2739138);
            4'd8:    m = RECIP_W'(2097152);
            default: m = RECIP_W'(134217728);
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/box_downscale_with_vertical_flip_unit.sv =====
// top level: box filter downscaler with vertical flip, config port and output register
// a block's last pixel reaches m_tvalid through accum s1 and s2, the divider register and the output register
// throughput: one pixel per cycle when not stalled; the column sum memory does one read and one write a cycle
// a write to the column being read in the same cycle is bypassed from the last-write register
// the whole pipeline stalls while the output register holds an untaken result
// reset (aresetn, synchronous): counters, valid bits and config registers return to defaults;
// the column sum memory is not cleared, every block loads its first pixel
module box_downscale_with_vertical_flip_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdvf_pkg::APB_AW-1:0]   paddr,
    input  logic [bdvf_pkg::APB_DW-1:0]   pwdata,
    output logic [bdvf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // pixel input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // red_in, green_in, blue_in
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // red_out, green_out, blue_out, out_col, out_row, zero pad
    output logic                          m_tlast    // frame_last
);

    logic [bdvf_pkg::CFG_W-1:0] out_width_reg;
    logic [bdvf_pkg::CFG_W-1:0] out_height_reg;
    logic [bdvf_pkg::FAC_W-1:0] factor_reg;

    logic [bdvf_pkg::IDX_W-1:0] reg_idx;
    logic                       cfg_wr;

    logic [bdvf_pkg::FAC_W-1:0] fac;
    logic [bdvf_pkg::CFG_W-1:0] wid;
    logic [bdvf_pkg::CFG_W-1:0] hgt;

    logic                       adv;
    logic                       accept;
    bdvf_pkg::rgb_t             pix_in;
    bdvf_pkg::item_ctl_t        ctl0;

    logic                       acc_valid;
    bdvf_pkg::item_ctl_t        acc_ctl;
    bdvf_pkg::sum_t             acc_sum;

    logic                       div_valid;
    bdvf_pkg::item_ctl_t        div_ctl;
    bdvf_pkg::rgb_t             div_mean;

    logic                       m_tvalid_reg;
    bdvf_pkg::rgb_t             mean_reg;
    logic [bdvf_pkg::COL_W-1:0] col_reg;
    logic [bdvf_pkg::ROW_W-1:0] row_reg;
    logic                       last_reg;

    // config registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[bdvf_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_width_reg  <= bdvf_pkg::CFG_W'(1);
            out_height_reg <= bdvf_pkg::CFG_W'(1);
            factor_reg     <= bdvf_pkg::FAC_W'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                bdvf_pkg::REG_OUT_WIDTH:  out_width_reg  <= pwdata[bdvf_pkg::CFG_W-1:0];
                bdvf_pkg::REG_OUT_HEIGHT: out_height_reg <= pwdata[bdvf_pkg::CFG_W-1:0];
                bdvf_pkg::REG_FACTOR:     factor_reg     <= pwdata[bdvf_pkg::FAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bdvf_pkg::REG_OUT_WIDTH:  prdata = bdvf_pkg::APB_DW'(out_width_reg);
            bdvf_pkg::REG_OUT_HEIGHT: prdata = bdvf_pkg::APB_DW'(out_height_reg);
            bdvf_pkg::REG_FACTOR:     prdata = bdvf_pkg::APB_DW'(factor_reg);
            default:                  prdata = '0;
        endcase
    end

    assign fac = bdvf_pkg::eff_factor(factor_reg);
    assign wid = bdvf_pkg::eff_width(out_width_reg);
    assign hgt = bdvf_pkg::eff_height(out_height_reg);

    // pipeline moves whenever the output register is free or being drained
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign pix_in.r = s_tdata[7:0];
    assign pix_in.g = s_tdata[15:8];
    assign pix_in.b = s_tdata[23:16];

    bdvf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .fac     (fac),
        .wid     (wid),
        .hgt     (hgt),
        .ctl     (ctl0)
    );

    bdvf_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .accept    (accept),
        .ctl_in    (ctl0),
        .pix_in    (pix_in),
        .valid_out (acc_valid),
        .ctl_out   (acc_ctl),
        .sum_out   (acc_sum)
    );

    bdvf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .fac       (fac),
        .valid_in  (acc_valid),
        .ctl_in    (acc_ctl),
        .sum_in    (acc_sum),
        .valid_out (div_valid),
        .ctl_out   (div_ctl),
        .mean_out  (div_mean)
    );

    // output register, only pixels that close a block make a transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= div_valid && div_ctl.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mean_reg <= div_mean;
            col_reg  <= div_ctl.col;
            row_reg  <= div_ctl.row;
            last_reg <= div_ctl.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, row_reg, col_reg, mean_reg.b, mean_reg.g, mean_reg.r};

`ifndef ASSERT_OFF
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid not cleared by reset");

    a_out_from_block_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(div_valid && div_ctl.emit))
        else $error("result raised without a block-closing pixel");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_no_move_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(div_ctl) && $stable(acc_valid) && $stable(div_valid))
        else $error("pipeline advanced while output stalled");
`endif

endmodule

// ===== rtl/bdvf_ram.sv =====
// generic simple dual-port ram with registered read
module bdvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bdvf_ctrl.sv =====
// block position counters and per-pixel control decode
module bdvf_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [bdvf_pkg::FAC_W-1:0]      fac,
    input  logic [bdvf_pkg::CFG_W-1:0]      wid,
    input  logic [bdvf_pkg::CFG_W-1:0]      hgt,
    output bdvf_pkg::item_ctl_t             ctl
);

    logic [bdvf_pkg::SUB_W-1:0] sub_col_reg, sub_col_next;
    logic [bdvf_pkg::SUB_W-1:0] sub_row_reg, sub_row_next;
    logic [bdvf_pkg::COL_W-1:0] col_index_reg, col_index_next;
    logic [bdvf_pkg::ROW_W-1:0] band_index_reg, band_index_next;

    logic last_sc, last_col, last_sr, last_band;

    assign last_sc   = (bdvf_pkg::FAC_W'(sub_col_reg) + 1'b1) >= fac;
    assign last_sr   = (bdvf_pkg::FAC_W'(sub_row_reg) + 1'b1) >= fac;
    assign last_col  = (bdvf_pkg::CFG_W'(col_index_reg) + 1'b1) >= wid;
    assign last_band = (bdvf_pkg::CFG_W'(band_index_reg) + 1'b1) >= hgt;

    always_comb begin
        ctl.col  = col_index_reg;
        // flipped row, wraps when the band sits beyond a shrunken height
        ctl.row  = bdvf_pkg::ROW_W'(hgt - 1'b1 - bdvf_pkg::CFG_W'(band_index_reg));
        ctl.last = last_col && last_band;
        ctl.emit = last_sc && last_sr;
        ctl.load = (sub_col_reg == '0) && (sub_row_reg == '0);
    end

    always_comb begin
        sub_col_next    = sub_col_reg;
        sub_row_next    = sub_row_reg;
        col_index_next  = col_index_reg;
        band_index_next = band_index_reg;
        if (!last_sc) begin
            sub_col_next = sub_col_reg + 1'b1;
        end else begin
            sub_col_next = '0;
            if (!last_col) begin
                col_index_next = col_index_reg + 1'b1;
            end else begin
                col_index_next = '0;
                if (!last_sr) begin
                    sub_row_next = sub_row_reg + 1'b1;
                end else begin
                    sub_row_next = '0;
                    if (!last_band) begin
                        band_index_next = band_index_reg + 1'b1;
                    end else begin
                        band_index_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_col_reg    <= '0;
            sub_row_reg    <= '0;
            col_index_reg  <= '0;
            band_index_reg <= '0;
        end else if (accept) begin
            sub_col_reg    <= sub_col_next;
            sub_row_reg    <= sub_row_next;
            col_index_reg  <= col_index_next;
            band_index_reg <= band_index_next;
        end
    end

endmodule

// ===== rtl/bdvf_accum.sv =====
// column sum memory with read-modify-write and write-to-read bypass
module bdvf_accum (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    accept,
    input  bdvf_pkg::item_ctl_t     ctl_in,
    input  bdvf_pkg::rgb_t          pix_in,
    output logic                    valid_out,
    output bdvf_pkg::item_ctl_t     ctl_out,
    output bdvf_pkg::sum_t          sum_out
);

    logic                      s1_valid_reg;
    bdvf_pkg::item_ctl_t       s1_ctl_reg;
    bdvf_pkg::rgb_t            s1_pix_reg;

    logic                      s2_valid_reg;
    bdvf_pkg::item_ctl_t       s2_ctl_reg;
    bdvf_pkg::sum_t            s2_sum_reg;

    // last write, replayed when it lands on the edge of a read of the same column
    logic                      byp_valid_reg;
    logic [bdvf_pkg::COL_W-1:0] byp_addr_reg;
    bdvf_pkg::sum_t            byp_data_reg;

    logic                      wr_en;
    logic [bdvf_pkg::RAM_W-1:0] rd_data;
    bdvf_pkg::sum_t            old_sum;
    bdvf_pkg::sum_t            sum_new;

    assign wr_en = adv && s1_valid_reg;

    bdvf_ram #(
        .WIDTH (bdvf_pkg::RAM_W),
        .DEPTH (bdvf_pkg::MAX_OUT_WIDTH)
    ) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_ctl_reg.col),
        .wr_data (sum_new),
        .rd_en   (accept),
        .rd_addr (ctl_in.col),
        .rd_data (rd_data)
    );

    always_comb begin
        if (byp_valid_reg && (byp_addr_reg == s1_ctl_reg.col)) begin
            old_sum = byp_data_reg;
        end else begin
            old_sum = rd_data;
        end
        if (s1_ctl_reg.load) begin
            sum_new.r = bdvf_pkg::SUM_W'(s1_pix_reg.r);
            sum_new.g = bdvf_pkg::SUM_W'(s1_pix_reg.g);
            sum_new.b = bdvf_pkg::SUM_W'(s1_pix_reg.b);
        end else begin
            sum_new.r = old_sum.r + bdvf_pkg::SUM_W'(s1_pix_reg.r);
            sum_new.g = old_sum.g + bdvf_pkg::SUM_W'(s1_pix_reg.g);
            sum_new.b = old_sum.b + bdvf_pkg::SUM_W'(s1_pix_reg.b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctl_reg <= ctl_in;
            s1_pix_reg <= pix_in;
            s2_ctl_reg <= s1_ctl_reg;
            s2_sum_reg <= sum_new;
            if (s1_valid_reg) begin
                byp_addr_reg <= s1_ctl_reg.col;
                byp_data_reg <= sum_new;
            end
        end
    end

    assign valid_out = s2_valid_reg;
    assign ctl_out   = s2_ctl_reg;
    assign sum_out   = s2_sum_reg;

endmodule

// ===== rtl/bdvf_div.sv =====
// block mean by reciprocal multiply, one registered stage
module bdvf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic [bdvf_pkg::FAC_W-1:0]  fac,
    input  logic                        valid_in,
    input  bdvf_pkg::item_ctl_t         ctl_in,
    input  bdvf_pkg::sum_t              sum_in,
    output logic                        valid_out,
    output bdvf_pkg::item_ctl_t         ctl_out,
    output bdvf_pkg::rgb_t              mean_out
);

    logic [bdvf_pkg::RECIP_W-1:0] mul;
    logic [bdvf_pkg::PROD_W-1:0]  prod_r, prod_g, prod_b;

    logic                         valid_reg;
    bdvf_pkg::item_ctl_t          ctl_reg;
    bdvf_pkg::rgb_t               mean_reg;

    assign mul    = bdvf_pkg::recip(fac);
    assign prod_r = bdvf_pkg::PROD_W'(sum_in.r) * bdvf_pkg::PROD_W'(mul);
    assign prod_g = bdvf_pkg::PROD_W'(sum_in.g) * bdvf_pkg::PROD_W'(mul);
    assign prod_b = bdvf_pkg::PROD_W'(sum_in.b) * bdvf_pkg::PROD_W'(mul);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    // only the low byte of the quotient is kept
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg    <= ctl_in;
            mean_reg.r <= prod_r[bdvf_pkg::RECIP_SHIFT +: bdvf_pkg::PIX_W];
            mean_reg.g <= prod_g[bdvf_pkg::RECIP_SHIFT +: bdvf_pkg::PIX_W];
            mean_reg.b <= prod_b[bdvf_pkg::RECIP_SHIFT +: bdvf_pkg::PIX_W];
        end
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign mean_out  = mean_reg;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the box downscaler with vertical flip
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY       = 3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 1370;
    localparam int WIDE_PIXELS   = 40;
    // frame size bound for random configurations, in supersampled pixels
    localparam int FRAME_BUDGET  = 160;

    typedef struct {
        logic [bdvf_pkg::PIX_W-1:0] r;
        logic [bdvf_pkg::PIX_W-1:0] g;
        logic [bdvf_pkg::PIX_W-1:0] b;
        logic [bdvf_pkg::COL_W-1:0] col;
        logic [bdvf_pkg::ROW_W-1:0] row;
        logic                       last;
    } block_mean_t;

    class downscale_scoreboard;
        logic [bdvf_pkg::SUM_W-1:0] acc_r [bdvf_pkg::MAX_OUT_WIDTH];
        logic [bdvf_pkg::SUM_W-1:0] acc_g [bdvf_pkg::MAX_OUT_WIDTH];
        logic [bdvf_pkg::SUM_W-1:0] acc_b [bdvf_pkg::MAX_OUT_WIDTH];
        int unsigned sub_col, sub_row, col_idx, band_idx;
        logic [bdvf_pkg::CFG_W-1:0] width_reg, height_reg;
        logic [bdvf_pkg::FAC_W-1:0] factor_reg;
        block_mean_t pending_means[$];
        int errors;

        function new();
            width_reg  = 1;
            height_reg = 1;
            factor_reg = 1;
            sub_col    = 0;
            sub_row    = 0;
            col_idx    = 0;
            band_idx   = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [bdvf_pkg::IDX_W-1:0] idx,
                              logic [bdvf_pkg::APB_DW-1:0] value);
            case (idx)
                bdvf_pkg::REG_OUT_WIDTH:  width_reg  = value[bdvf_pkg::CFG_W-1:0];
                bdvf_pkg::REG_OUT_HEIGHT: height_reg = value[bdvf_pkg::CFG_W-1:0];
                bdvf_pkg::REG_FACTOR:     factor_reg = value[bdvf_pkg::FAC_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned block_side();
            if (factor_reg == 0) return 1;
            return (factor_reg > bdvf_pkg::MAX_FACTOR) ? bdvf_pkg::MAX_FACTOR : factor_reg;
        endfunction

        function int unsigned frame_cols();
            if (width_reg == 0) return 1;
            return (width_reg > bdvf_pkg::MAX_OUT_WIDTH) ? bdvf_pkg::MAX_OUT_WIDTH : width_reg;
        endfunction

        function int unsigned frame_rows();
            if (height_reg == 0) return 1;
            return (height_reg > bdvf_pkg::ROW_LIMIT) ? bdvf_pkg::ROW_LIMIT : height_reg;
        endfunction

        function bit at_frame_start();
            return sub_col == 0 && sub_row == 0 && col_idx == 0 && band_idx == 0;
        endfunction

        function void accumulate_pixel(logic [23:0] px);
            int unsigned f, w, h, c, area;
            bit end_sc, end_col, end_sr, end_band;
            block_mean_t m;
            f = block_side();
            w = frame_cols();
            h = frame_rows();
            end_sc   = sub_col + 1 >= f;
            end_col  = col_idx + 1 >= w;
            end_sr   = sub_row + 1 >= f;
            end_band = band_idx + 1 >= h;
            c = (col_idx >= bdvf_pkg::MAX_OUT_WIDTH) ? bdvf_pkg::MAX_OUT_WIDTH - 1 : col_idx;
            // first pixel of a block starts a fresh sum
            if (sub_col == 0 && sub_row == 0) begin
                acc_r[c] = bdvf_pkg::SUM_W'(px[7:0]);
                acc_g[c] = bdvf_pkg::SUM_W'(px[15:8]);
                acc_b[c] = bdvf_pkg::SUM_W'(px[23:16]);
            end else begin
                acc_r[c] = acc_r[c] + bdvf_pkg::SUM_W'(px[7:0]);
                acc_g[c] = acc_g[c] + bdvf_pkg::SUM_W'(px[15:8]);
                acc_b[c] = acc_b[c] + bdvf_pkg::SUM_W'(px[23:16]);
            end
            if (end_sc && end_sr) begin
                area   = f * f;
                m.r    = bdvf_pkg::PIX_W'(acc_r[c] / area);
                m.g    = bdvf_pkg::PIX_W'(acc_g[c] / area);
                m.b    = bdvf_pkg::PIX_W'(acc_b[c] / area);
                m.col  = bdvf_pkg::COL_W'(col_idx);
                // flipped row, wraps when the band is past a shrunken height
                m.row  = bdvf_pkg::ROW_W'(h - 1 - band_idx);
                m.last = end_col && end_band;
                pending_means = {pending_means, m};
            end
            if (!end_sc) begin
                sub_col++;
            end else begin
                sub_col = 0;
                if (!end_col) begin
                    col_idx++;
                end else begin
                    col_idx = 0;
                    if (!end_sr) begin
                        sub_row++;
                    end else begin
                        sub_row  = 0;
                        band_idx = end_band ? 0 : band_idx + 1;
                    end
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(logic [47:0] data, logic last);
            block_mean_t m;
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %h last %b",
                         $time, data, last);
                errors++;
                return;
            end
            m = pending_means.pop_front();
            compare_field("red", m.r, data[7:0]);
            compare_field("green", m.g, data[15:8]);
            compare_field("blue", m.b, data[23:16]);
            compare_field("out_col", m.col, data[34:24]);
            compare_field("out_row", m.row, data[45:35]);
            compare_field("frame_last", m.last, last);
        endfunction
    endclass

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [bdvf_pkg::APB_AW-1:0]   paddr   = '0;
    logic [bdvf_pkg::APB_DW-1:0]   pwdata  = '0;
    logic [bdvf_pkg::APB_DW-1:0]   prdata;
    logic                          pready;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata  = '0;   // red_in, green_in, blue_in
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [47:0]                   m_tdata;         // red_out, green_out, blue_out, out_col, out_row, pad
    logic                          m_tlast;         // frame_last

    downscale_scoreboard sb;
    bit quiet_in  = 1'b0;
    bit quiet_out = 1'b0;
    int pixels_sent = 0;
    int idle_cycles = 0;

    box_downscale_with_vertical_flip_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 5));
    endfunction

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(input logic [23:0] px);
        int gap;
        gap = draw_wait(quiet_in);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.accumulate_pixel(px);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) send_pixel({rand_channel(), rand_channel(), rand_channel()});
    endtask

    // hold off the input until every pending mean is out and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_means.size() != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [bdvf_pkg::IDX_W-1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned f);
        settle();
        write_reg(bdvf_pkg::REG_OUT_WIDTH, w);
        write_reg(bdvf_pkg::REG_OUT_HEIGHT, h);
        write_reg(bdvf_pkg::REG_FACTOR, f);
    endtask

    initial begin
        int unsigned f, w, h, side, maxw, maxh, n;
        int target;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset config: every pixel is its own block and its own frame
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hA55A0F);
        send_pixel(24'h5AA5F0);
        // 2x2 blocks on a 4x4 input image, sums that do not divide evenly
        configure(2, 2, 2);
        for (int i = 0; i < 16; i++) begin
            send_pixel((i % 3 == 0) ? 24'hFFFFFF : ((i % 3 == 1) ? 24'h000000 : 24'h01FE7F));
        end
        // zero registers act as one
        configure(0, 0, 0);
        send_pixel(24'h123456);
        send_pixel(24'hFEDCBA);

        // oversized factor clamps to the largest block
        configure(1, 1, 15);
        send_random(64);
        // oversized width clamps to the widest frame, first columns get a sum each
        configure(4095, 1, 1);
        send_random(WIDE_PIXELS);
        // tallest frame: bottom rows map to the top of the row range
        configure(1, 4095, 1);
        send_random(5);
        // height shrinks mid-frame while the band is past the new limit
        settle();
        write_reg(bdvf_pkg::REG_OUT_HEIGHT, 1);
        send_random(2);

        target = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < target) begin
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            if (sb.at_frame_start() && $urandom_range(0, 2) == 0) begin
                settle();
                case ($urandom_range(0, 9))
                    0:       f = 0;
                    1:       f = $urandom_range(5, 15);
                    default: f = $urandom_range(1, 4);
                endcase
                write_reg(bdvf_pkg::REG_FACTOR, f);
                side = sb.block_side();
                maxw = FRAME_BUDGET / (side * side);
                maxw = (maxw > 8) ? 8 : ((maxw == 0) ? 1 : maxw);
                w = $urandom_range(1, maxw);
                maxh = FRAME_BUDGET / (side * side * w);
                maxh = (maxh > 6) ? 6 : ((maxh == 0) ? 1 : maxh);
                h = $urandom_range(1, maxh);
                write_reg(bdvf_pkg::REG_OUT_WIDTH, ($urandom_range(0, 9) == 0) ? 0 : w);
                write_reg(bdvf_pkg::REG_OUT_HEIGHT, ($urandom_range(0, 9) == 0) ? 0 : h);
            end else if (!sb.at_frame_start() && $urandom_range(0, 7) == 0) begin
                // mid-frame change, counters keep their values
                settle();
                case ($urandom_range(0, 2))
                    0:       write_reg(bdvf_pkg::REG_OUT_WIDTH, $urandom_range(0, 6));
                    1:       write_reg(bdvf_pkg::REG_OUT_HEIGHT, $urandom_range(0, 6));
                    default: write_reg(bdvf_pkg::REG_FACTOR, $urandom_range(0, 4));
                endcase
            end
            n = $urandom_range(1, 60);
            for (int i = 0; i < n; i++) begin
                send_pixel({rand_channel(), rand_channel(), rand_channel()});
                if (sb.at_frame_start()) break;
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // output side: random stall before each transfer
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = draw_wait(quiet_out);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_pixel(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
rtl/bdvf_pkg.sv
rtl/bdvf_ram.sv
rtl/bdvf_ctrl.sv
rtl/bdvf_accum.sv
rtl/bdvf_div.sv
rtl/box_downscale_with_vertical_flip_unit.sv
tb/tb.sv
